// File: rtl/hrfp_pkg.sv
// shared types and constants of the h264 rtp fu-a packetizer
`default_nettype none

package hrfp_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_FRAGMENT   = 2'd0;
    localparam logic [1:0] CFG_PAYLOAD_TYPE   = 2'd1;
    localparam logic [1:0] CFG_SOURCE_ID      = 2'd2;
    localparam logic [1:0] CFG_TIMESTAMP_STEP = 2'd3;

    // configuration reset values
    localparam logic [10:0] RST_MAX_FRAGMENT   = 11'd1300;
    localparam logic [6:0]  RST_PAYLOAD_TYPE   = 7'd96;
    localparam logic [31:0] RST_SOURCE_ID      = 32'h9876_5432;
    localparam logic [31:0] RST_TIMESTAMP_STEP = 32'(90000 / 24);

    // packet format constants
    localparam logic [7:0]  RTP_VERSION_BYTE = 8'h80;
    localparam logic [7:0]  FU_INDICATOR     = 8'h60 | 8'd28;
    localparam logic [7:0]  FU_START_BIT     = 8'h80;
    localparam logic [7:0]  FU_END_BIT       = 8'h40;
    localparam logic [7:0]  NAL_TYPE_MASK    = 8'h1F;
    localparam logic [10:0] MIN_FRAGMENT     = 11'd16;
    localparam logic [10:0] FILL_MAX         = 11'h7FF;
    localparam logic [19:0] POS_MAX          = 20'hF_FFFF;
    localparam int          HDR_BYTES        = 12;

    // back end byte sequencer steps
    localparam logic [3:0] STEP_FU_IND = 4'd12;
    localparam logic [3:0] STEP_FU_HDR = 4'd13;
    localparam logic [3:0] STEP_DATA   = 4'd14;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [10:0] max_fragment;
        logic [6:0]  payload_type;
        logic [31:0] source_id;
        logic [31:0] timestamp_step;
    } cfg_t;

    // one classified item: a payload byte and what precedes it
    typedef struct packed {
        logic [7:0]  data;
        logic        hdr;
        logic        fu;
        logic [7:0]  fu_hdr;
        logic        pe;
        logic        fe;
        logic [15:0] seq;
        logic [31:0] ts;
    } entry_t;

endpackage

`default_nettype wire

// File: rtl/hrfp_front.sv
// front end: start code removal, nal classification, fragmentation and counters
`default_nettype none

module hrfp_front #(
    parameter int unsigned MAX_FRAME_BYTES = 1048576
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  hrfp_pkg::cfg_t       cfg,
    input  wire                  accept,
    input  wire  [7:0]           data_byte,
    input  wire                  frame_start,
    input  wire  [20:0]          frame_length,
    output logic                 push,
    output hrfp_pkg::entry_t     push_entry
);

    localparam int unsigned SIZE_CAP = (MAX_FRAME_BYTES < 32'd2097151) ?
                                       MAX_FRAME_BYTES : 32'd2097151;
    localparam int LEFT_W = $clog2(SIZE_CAP + 1);

    logic [19:0]       pos_reg, pos_next;
    logic              scl_reg, scl_next;
    logic [7:0]        nal_reg, nal_next;
    logic              mode_reg, mode_next;
    logic [10:0]       fill_reg, fill_next;
    logic [LEFT_W-1:0] left_reg, left_next;
    logic [15:0]       seq_reg, seq_next;
    logic [31:0]       ts_reg, ts_next;

    logic [19:0]       p;
    logic              scl_eff;
    logic [2:0]        sep;
    logic [10:0]       mf;
    logic [LEFT_W-1:0] size_eff, len, mf_w, left_dec;
    logic [10:0]       fill_inc;
    logic              first_chunk, close_pkt, done;
    logic              emit;
    hrfp_pkg::entry_t  ent;

    // per byte classification
    always_comb
    begin
        p        = frame_start ? 20'd0 : pos_reg;
        pos_next = (p != hrfp_pkg::POS_MAX) ? p + 20'd1 : p;
        scl_next  = scl_reg;
        nal_next  = nal_reg;
        mode_next = mode_reg;
        fill_next = fill_reg;
        left_next = left_reg;
        seq_next  = seq_reg;
        ts_next   = ts_reg;
        emit      = 1'b0;

        mf   = (cfg.max_fragment < hrfp_pkg::MIN_FRAGMENT) ?
               hrfp_pkg::MIN_FRAGMENT : cfg.max_fragment;
        mf_w = LEFT_W'(mf);
        scl_eff = (p == 20'd3) ? 1'b0 : scl_reg;
        sep     = scl_eff ? 3'd4 : 3'd3;
        size_eff = (32'(frame_length) > SIZE_CAP) ? LEFT_W'(SIZE_CAP) : LEFT_W'(frame_length);
        len      = (size_eff > LEFT_W'(sep)) ? size_eff - LEFT_W'(sep) : LEFT_W'(1);
        left_dec = left_reg - LEFT_W'(1);
        fill_inc = (fill_reg != hrfp_pkg::FILL_MAX) ? fill_reg + 11'd1 : fill_reg;
        first_chunk = (p == 20'(sep) + 20'(fill_inc));
        done        = (left_dec == '0);
        close_pkt   = done || (fill_inc >= mf) || (first_chunk && left_dec == LEFT_W'(1));

        ent.data   = data_byte;
        ent.hdr    = 1'b0;
        ent.fu     = 1'b0;
        ent.fu_hdr = nal_reg & hrfp_pkg::NAL_TYPE_MASK;
        ent.pe     = 1'b0;
        ent.fe     = 1'b0;
        ent.seq    = seq_reg;
        ent.ts     = ts_reg;

        if (p < 20'd3)
        begin
            // start code prefix bytes
            if (p == 20'd0)
            begin
                scl_next  = (data_byte == 8'd0);
                left_next = '0;
                fill_next = '0;
                mode_next = 1'b0;
            end
            else
            begin
                scl_next = scl_reg && (data_byte == 8'd0);
            end
        end
        else if (p == 20'd3 && scl_reg && data_byte == 8'd1)
        begin
            // last byte of a long start code
            scl_next = scl_reg;
        end
        else
        begin
            scl_next = scl_eff;
            if (p == 20'(sep))
            begin
                // nal header byte
                left_next = len - LEFT_W'(1);
                fill_next = '0;
                if (len <= mf_w)
                begin
                    mode_next = 1'b0;
                    emit      = 1'b1;
                    ent.hdr   = 1'b1;
                    ent.pe    = (len == LEFT_W'(1));
                    ent.fe    = (len == LEFT_W'(1));
                    if (len == LEFT_W'(1))
                    begin
                        seq_next = seq_reg + 16'd1;
                        ts_next  = ts_reg + cfg.timestamp_step;
                    end
                end
                else
                begin
                    mode_next = 1'b1;
                    nal_next  = data_byte;
                end
            end
            else if (left_reg != '0)
            begin
                emit      = 1'b1;
                left_next = left_dec;
                if (!mode_reg)
                begin
                    // single nal unit packet body
                    ent.pe = done;
                    ent.fe = done;
                    if (done)
                    begin
                        seq_next = seq_reg + 16'd1;
                        ts_next  = ts_reg + cfg.timestamp_step;
                    end
                end
                else
                begin
                    // fu-a fragment body
                    if (fill_reg == '0)
                    begin
                        ent.hdr = 1'b1;
                        ent.fu  = 1'b1;
                        if (p == 20'(sep) + 20'd1)
                        begin
                            ent.fu_hdr = ent.fu_hdr | hrfp_pkg::FU_START_BIT;
                        end
                        else if (left_reg <= mf_w)
                        begin
                            ent.fu_hdr = ent.fu_hdr | hrfp_pkg::FU_END_BIT;
                        end
                    end
                    fill_next = fill_inc;
                    ent.pe    = close_pkt;
                    ent.fe    = done;
                    if (close_pkt)
                    begin
                        seq_next  = seq_reg + 16'd1;
                        fill_next = '0;
                    end
                    if (done)
                    begin
                        ts_next = ts_reg + cfg.timestamp_step;
                    end
                end
            end
        end
    end

    assign push       = accept && emit;
    assign push_entry = ent;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            scl_reg  <= 1'b0;
            nal_reg  <= '0;
            mode_reg <= 1'b0;
            fill_reg <= '0;
            left_reg <= '0;
            seq_reg  <= '0;
            ts_reg   <= '0;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            scl_reg  <= scl_next;
            nal_reg  <= nal_next;
            mode_reg <= mode_next;
            fill_reg <= fill_next;
            left_reg <= left_next;
            seq_reg  <= seq_next;
            ts_reg   <= ts_next;
        end
    end

    // a frame end always closes its packet
    a_fe_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_entry.fe) |-> push_entry.pe)
        else $error("frame end item without packet end");

endmodule

`default_nettype wire

// File: rtl/hrfp_queue.sv
// short item queue between front end and back end
`default_nettype none

module hrfp_queue (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    input  hrfp_pkg::entry_t   push_entry,
    input  wire                pop,
    output logic               full,
    output logic               head_valid,
    output hrfp_pkg::entry_t   head
);

    localparam int CNT_W = hrfp_pkg::QPTR_W + 1;

    hrfp_pkg::entry_t                 mem_reg [hrfp_pkg::QUEUE_DEPTH];
    logic [hrfp_pkg::QPTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]                 count_reg;

    assign full       = (count_reg == CNT_W'(hrfp_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

// File: rtl/hrfp_back.sv
// back end: expands queued items into rtp header, fu-a bytes and payload
`default_nettype none

module hrfp_back (
    input  wire                clk,
    input  wire                rst_n,
    input  hrfp_pkg::cfg_t     cfg,
    input  wire                head_valid,
    input  hrfp_pkg::entry_t   head,
    output logic               pop,
    output logic               out_valid,
    input  wire                out_stall,
    output logic [7:0]         out_byte,
    output logic               packet_end,
    output logic               frame_end
);

    logic [3:0]  step_reg, step_next;
    logic [3:0]  cur_step;
    logic        load;
    logic        last_step;
    logic [95:0] hdr_vec;
    logic [7:0]  byte_sel;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        packet_end_reg, frame_end_reg;

    // step selection and byte mux
    always_comb
    begin
        if (!head.hdr || (!head.fu && step_reg >= hrfp_pkg::STEP_FU_IND))
        begin
            cur_step = hrfp_pkg::STEP_DATA;
        end
        else
        begin
            cur_step = step_reg;
        end
        hdr_vec = {hrfp_pkg::RTP_VERSION_BYTE, 1'b0, cfg.payload_type,
                   head.seq, head.ts, cfg.source_id};
        if (cur_step < 4'(hrfp_pkg::HDR_BYTES))
        begin
            byte_sel = hdr_vec[(4'(hrfp_pkg::HDR_BYTES - 1) - cur_step) * 8 +: 8];
        end
        else if (cur_step == hrfp_pkg::STEP_FU_IND)
        begin
            byte_sel = hrfp_pkg::FU_INDICATOR;
        end
        else if (cur_step == hrfp_pkg::STEP_FU_HDR)
        begin
            byte_sel = head.fu_hdr;
        end
        else
        begin
            byte_sel = head.data;
        end
        last_step = (cur_step == hrfp_pkg::STEP_DATA);
        load      = head_valid && (!out_valid_reg || !out_stall);
        pop       = load && last_step;
        if (pop)
        begin
            step_next = '0;
        end
        else if (load)
        begin
            step_next = cur_step + 4'd1;
        end
        else
        begin
            step_next = step_reg;
        end
    end

    // sequencer and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg   <= byte_sel;
            packet_end_reg <= last_step && head.pe;
            frame_end_reg  <= last_step && head.fe;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign packet_end = packet_end_reg;
    assign frame_end  = frame_end_reg;

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= hrfp_pkg::STEP_FU_HDR + 4'd1)
        else $error("byte sequencer step out of range");

    a_pop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (step_reg == '0))
        else $error("sequencer did not restart after an item");

endmodule

`default_nettype wire

// File: rtl/h264_rtp_fua_packetizer_unit.sv
// top level of the h264 rtp fu-a packetizer
`default_nettype none

// Takes one Annex B frame byte per item and sends RTP packets as a byte
// stream, one output byte per cycle when the sink does not stall. The front
// end takes one input byte per cycle as long as its four-entry queue has
// room; the back end's byte sequencer sends each payload byte, preceded by
// the 12 RTP header bytes for each single-unit packet and by 14 header bytes
// for each FU-A packet (RTP header, indicator, FU header). Start code bytes
// and bytes past frame_length are taken but produce no output.

module h264_rtp_fua_packetizer_unit #(
    parameter int unsigned MAX_FRAME_BYTES = 1048576
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_write,
    input  wire  [1:0]  cfg_index,
    input  wire  [31:0] cfg_data,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [7:0]  data_byte,
    input  wire         frame_start,
    input  wire  [20:0] frame_length,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [7:0]  out_byte,
    output logic        packet_end,
    output logic        frame_end
);

    hrfp_pkg::cfg_t   cfg_reg;
    hrfp_pkg::entry_t push_entry, head;
    logic             accept, push, pop, full, head_valid;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_fragment   <= hrfp_pkg::RST_MAX_FRAGMENT;
            cfg_reg.payload_type   <= hrfp_pkg::RST_PAYLOAD_TYPE;
            cfg_reg.source_id      <= hrfp_pkg::RST_SOURCE_ID;
            cfg_reg.timestamp_step <= hrfp_pkg::RST_TIMESTAMP_STEP;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                hrfp_pkg::CFG_MAX_FRAGMENT:   cfg_reg.max_fragment   <= cfg_data[10:0];
                hrfp_pkg::CFG_PAYLOAD_TYPE:   cfg_reg.payload_type   <= cfg_data[6:0];
                hrfp_pkg::CFG_SOURCE_ID:      cfg_reg.source_id      <= cfg_data;
                hrfp_pkg::CFG_TIMESTAMP_STEP: cfg_reg.timestamp_step <= cfg_data;
                default:                      cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input handshake
    assign in_stall = full;
    assign accept   = in_valid && !full;

    hrfp_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .accept       (accept),
        .data_byte    (data_byte),
        .frame_start  (frame_start),
        .frame_length (frame_length),
        .push         (push),
        .push_entry   (push_entry)
    );

    hrfp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    hrfp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .packet_end (packet_end),
        .frame_end  (frame_end)
    );

endmodule

`default_nettype wire
